// File: design/hsec_pkg.sv
// ----------------------------------------------------------------------------
// Hamming SEC package
// Shared widths, types and constant functions for the Hamming single-error
// correcting encoder and checker.
// ----------------------------------------------------------------------------
package hsec_pkg;

	// Fixed field widths.
	localparam int CodeW = 63;
	localparam int SynW = 6;
	localparam int CfgW = 6;

	// Configuration defaults.
	localparam int DataBitsReset = 8;
	localparam int MaxCodeBitsDefault = 63;

	typedef logic [CodeW-1:0] code_t;
	typedef logic [SynW-1:0] syn_t;

	// Operation codes carried on the op field.
	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_CHECK  = 1'b1
	} op_t;

	// Derived code geometry, held after every configuration write.
	typedef struct packed {
		syn_t  code_len;
		code_t data_mask;
		code_t code_mask;
	} hsec_cfg_t;

	// Number of check bits for m data bits: smallest r with 2^r >= m + r + 1.
	function automatic int check_bits_for(int m);
		int r;
		r = 0;
		for (int i = 0; i < 7; i++) begin
			if ((1 << r) < m + r + 1) begin
				r = r + 1;
			end
		end
		return r;
	endfunction

	// Largest data length whose codeword fits in max_code positions.
	function automatic int max_data_bits(int max_code);
		int maxm;
		maxm = 1;
		for (int c = 2; c <= CodeW; c++) begin
			if (maxm == c - 1 && c + check_bits_for(c) <= max_code) begin
				maxm = c;
			end
		end
		return maxm;
	endfunction

	// True when position p is a power of two (a check bit position).
	function automatic bit is_pow2(int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// Index of the data bit stored at a non-power-of-two position p.
	function automatic int data_index(int p);
		int lg;
		lg = 0;
		for (int i = 1; i < 7; i++) begin
			if ((p >> i) != 0) begin
				lg = i;
			end
		end
		return p - lg - 2;
	endfunction

	// Positions (bit p-1) whose position number has bit k set.
	function automatic code_t group_mask(int k);
		code_t g;
		g = '0;
		for (int p = 1; p <= CodeW; p++) begin
			g[p-1] = ((p >> k) & 1) != 0;
		end
		return g;
	endfunction

	// Clamp a raw data length and derive the code length and masks.
	function automatic hsec_cfg_t derive_cfg(logic [CfgW-1:0] m_raw,
			logic [CfgW-1:0] max_m);
		hsec_cfg_t  c;
		logic [CfgW-1:0] m;
		logic [3:0] r;
		m = m_raw;
		if (m == '0) begin
			m = CfgW'(1);
		end
		if (m > max_m) begin
			m = max_m;
		end
		r = '0;
		for (int i = 0; i < 7; i++) begin
			if ((8'd1 << r) < (8'(m) + 8'(r) + 8'd1)) begin
				r = r + 4'd1;
			end
		end
		c.code_len = SynW'(m) + SynW'(r);
		for (int i = 0; i < CodeW; i++) begin
			c.data_mask[i] = (7'(i) < {1'b0, m});
			c.code_mask[i] = (7'(i) < {1'b0, c.code_len});
		end
		return c;
	endfunction

endpackage

// File: design/hamming_sec_encode_correct_unit.sv
// ----------------------------------------------------------------------------
// Hamming SEC encode and correct unit
// Takes one item per clock cycle while the output side does not stall.
// Each item is held in the input register, passes through the parity
// trees and correction logic, and is held in the result register. The
// result register and input register together hold two items in flight.
// The data length register is written through its own channel, by the user
// only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct_unit #(
	parameter int MAX_CODE_BITS = hsec_pkg::MaxCodeBitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hsec_pkg::CfgW-1:0]   cfg_data,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [hsec_pkg::CodeW-1:0]  word,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hsec_pkg::CodeW-1:0]  codeword,
	output logic [hsec_pkg::SynW-1:0]   syndrome,
	output logic                        error_seen
);

	hsec_pkg::hsec_cfg_t cfg;

	logic            valid_s1;
	logic            op_s1;
	hsec_pkg::code_t word_s1;

	logic            valid_s2;
	hsec_pkg::code_t codeword_s2;
	hsec_pkg::syn_t  syndrome_s2;
	logic            error_seen_s2;

	hsec_pkg::code_t core_codeword;
	hsec_pkg::syn_t  core_syndrome;
	logic            core_error_seen;

	logic            adv_s2;
	logic            adv_s1;
	logic            in_xfer;

	// Configuration register.
	hsec_cfg #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Encode or check between the two registers.
	hsec_core u_core (
		.cfg        (cfg),
		.op         (op_s1),
		.word       (word_s1),
		.codeword   (core_codeword),
		.syndrome   (core_syndrome),
		.error_seen (core_error_seen)
	);

	// Pipeline flow: each stage loads when it is empty or its contents move on.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= op;
			word_s1 <= word;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			codeword_s2   <= core_codeword;
			syndrome_s2   <= core_syndrome;
			error_seen_s2 <= core_error_seen;
		end
	end

	assign out_valid  = valid_s2;
	assign codeword   = codeword_s2;
	assign syndrome   = syndrome_s2;
	assign error_seen = error_seen_s2;

endmodule

// File: design/hsec_cfg.sv
// ----------------------------------------------------------------------------
// Hamming SEC configuration register
// Holds the data length register in derived form: code length, data mask
// and codeword mask, worked out when the register is written.
// ----------------------------------------------------------------------------
module hsec_cfg #(
	parameter int MAX_CODE_BITS = hsec_pkg::MaxCodeBitsDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hsec_pkg::CfgW-1:0]  cfg_data,
	output hsec_pkg::hsec_cfg_t        cfg
);

	localparam int MaxM = hsec_pkg::max_data_bits(MAX_CODE_BITS);
	localparam hsec_pkg::hsec_cfg_t ResetCfg = hsec_pkg::derive_cfg(
		hsec_pkg::CfgW'(hsec_pkg::DataBitsReset), hsec_pkg::CfgW'(MaxM));

	hsec_pkg::hsec_cfg_t cfg_q;

	// A write is always taken.
	assign cfg_ready = 1'b1;

	// Clamp and derive the geometry on every write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ResetCfg;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= hsec_pkg::derive_cfg(cfg_data, hsec_pkg::CfgW'(MaxM));
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/hsec_core.sv
// ----------------------------------------------------------------------------
// Hamming SEC datapath
// Encodes a data word or checks and corrects a codeword in one pass of
// XOR trees, using the geometry held in the configuration register.
// ----------------------------------------------------------------------------
module hsec_core (
	input  hsec_pkg::hsec_cfg_t  cfg,
	input  logic                 op,
	input  hsec_pkg::code_t      word,
	output hsec_pkg::code_t      codeword,
	output hsec_pkg::syn_t       syndrome,
	output logic                 error_seen
);

	hsec_pkg::code_t word_d;
	hsec_pkg::code_t word_c;
	hsec_pkg::code_t placed;
	hsec_pkg::code_t par_in;
	hsec_pkg::code_t encoded;
	hsec_pkg::code_t flip;
	hsec_pkg::syn_t  par;
	logic            is_check;

	assign is_check = (op == hsec_pkg::OP_CHECK);

	// Drop data bits beyond the data length and received bits beyond the code.
	assign word_d = word & cfg.data_mask;
	assign word_c = word & cfg.code_mask;

	// Scatter the data bits into the positions that are not powers of two.
	for (genvar p = 1; p <= hsec_pkg::CodeW; p++) begin : g_place
		if (hsec_pkg::is_pow2(p)) begin : g_chk
			assign placed[p-1] = 1'b0;
		end else begin : g_dat
			assign placed[p-1] = word_d[hsec_pkg::data_index(p)];
		end
	end

	// Parity groups: on encode the check positions are still zero, so the
	// same trees give the check bits and, on check, the syndrome.
	assign par_in = is_check ? word_c : placed;

	for (genvar k = 0; k < hsec_pkg::SynW; k++) begin : g_par
		localparam hsec_pkg::code_t GroupMask = hsec_pkg::group_mask(k);
		assign par[k] = ^(par_in & GroupMask);
	end

	// Insert the check bits at their power-of-two positions.
	always_comb begin
		encoded = placed;
		for (int k = 0; k < hsec_pkg::SynW; k++) begin
			encoded[(1 << k) - 1] = par[k];
		end
	end

	// One-hot flip at the named position; a position beyond the code is
	// removed again by the codeword mask.
	always_comb begin
		for (int i = 0; i < hsec_pkg::CodeW; i++) begin
			flip[i] = (par == hsec_pkg::SynW'(i + 1));
		end
	end

	// Select the result of the operation.
	always_comb begin
		if (is_check) begin
			codeword   = (word_c ^ flip) & cfg.code_mask;
			syndrome   = par;
			error_seen = (par != '0);
		end else begin
			codeword   = encoded & cfg.code_mask;
			syndrome   = '0;
			error_seen = 1'b0;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming SEC encode and correct unit testbench
// This bench programs the data length register at several settings, the
// extremes among them. A short table of directed words runs first, then
// random phases with raw data, noise words and codewords carrying zero, one
// or two bit flips. Each result is checked against a typed row or an in-bench
// Hamming predictor, under bursty input traffic and shifting output stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MaxCodeBits = 63;
	localparam int CycleLimit = 400000;
	localparam int RandomPhases = 16;
	localparam int ItemsPerPhase = 94;
	localparam int DirectedRows = 21;
	localparam hsec_pkg::code_t AllOnes = {hsec_pkg::CodeW{1'b1}};

	typedef struct packed {
		hsec_pkg::code_t cw;
		hsec_pkg::syn_t  syn;
		logic            err;
	} result_t;

	typedef struct packed {
		bit                        wr_cfg;
		logic [hsec_pkg::CfgW-1:0] cfg;
		hsec_pkg::op_t             op;
		hsec_pkg::code_t           word;
		bit                        typed;
		result_t                   want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [hsec_pkg::CfgW-1:0] cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	hsec_pkg::op_t             in_op;
	hsec_pkg::code_t           in_word;
	logic                      out_valid;
	logic                      out_stall;
	hsec_pkg::code_t           codeword;
	hsec_pkg::syn_t            syndrome;
	logic                      error_seen;

	// Shadow of the data length register and the results still to come.
	logic [hsec_pkg::CfgW-1:0] cfg_shadow;
	result_t                   awaited_results[$];
	result_t                   got_want;
	int                        fail_count;
	int                        burst_left;

	// Directed words. The data length is 8 (12-bit codeword) until the first
	// register write in the table.
	stim_row_t directed_rows [DirectedRows] = '{
		'{1'b0, 6'd0, hsec_pkg::OP_ENCODE, 63'h0, 1'b1, '{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_ENCODE, 63'hFF, 1'b0, '{63'h0, 6'd0, 1'b0}},
		// Data bits above the data length are ignored.
		'{1'b0, 6'd0, hsec_pkg::OP_ENCODE, 63'h7FFF_FFFF_FFFF_FF00, 1'b1,
			'{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h0, 1'b1, '{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h1, 1'b1, '{63'h0, 6'd1, 1'b1}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h800, 1'b1, '{63'h0, 6'd12, 1'b1}},
		// Syndrome names a position past the codeword: nothing is flipped.
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h801, 1'b1, '{63'h801, 6'd13, 1'b1}},
		// Received bits above the codeword are ignored.
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h7FFF_FFFF_FFFF_F000, 1'b1,
			'{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, AllOnes, 1'b0, '{63'h0, 6'd0, 1'b0}},
		// A data length of zero acts as one.
		'{1'b1, 6'd0, hsec_pkg::OP_ENCODE, 63'h1, 1'b0, '{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, AllOnes, 1'b0, '{63'h0, 6'd0, 1'b0}},
		// Lengths above the largest one that fits saturate to 57.
		'{1'b1, 6'd63, hsec_pkg::OP_ENCODE, AllOnes, 1'b0, '{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h4000_0000_0000_0000, 1'b1,
			'{63'h0, 6'd63, 1'b1}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, AllOnes, 1'b1, '{AllOnes, 6'd0, 1'b0}},
		'{1'b1, 6'd57, hsec_pkg::OP_ENCODE, 63'h01AA_AAAA_AAAA_AAAA, 1'b0,
			'{63'h0, 6'd0, 1'b0}},
		'{1'b1, 6'd58, hsec_pkg::OP_CHECK, 63'h2, 1'b1, '{63'h0, 6'd2, 1'b1}},
		'{1'b1, 6'd1, hsec_pkg::OP_ENCODE, 63'h7FFF_FFFF_FFFF_FFFE, 1'b1,
			'{63'h0, 6'd0, 1'b0}},
		'{1'b1, 6'd4, hsec_pkg::OP_ENCODE, 63'hF, 1'b0, '{63'h0, 6'd0, 1'b0}},
		'{1'b0, 6'd0, hsec_pkg::OP_CHECK, 63'h55, 1'b0, '{63'h0, 6'd0, 1'b0}},
		'{1'b1, 6'd5, hsec_pkg::OP_CHECK, 63'h88, 1'b1, '{63'h88, 6'd12, 1'b1}},
		'{1'b0, 6'd0, hsec_pkg::OP_ENCODE, 63'h1F, 1'b0, '{63'h0, 6'd0, 1'b0}}
	};

	// Data length of the first ten random phases; the rest are drawn at random.
	logic [hsec_pkg::CfgW-1:0] phase_cfg [10] = '{6'd0, 6'd1, 6'd57, 6'd63, 6'd2,
		6'd3, 6'd4, 6'd11, 6'd26, 6'd58};

	hamming_sec_encode_correct_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (in_op),
		.word       (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.codeword   (codeword),
		.syndrome   (syndrome),
		.error_seen (error_seen)
	);

	// Smallest number of check bits r with 2^r >= m + r + 1.
	function automatic int check_len_of(int m);
		int r;
		r = 0;
		while ((1 << r) < m + r + 1) begin
			r++;
		end
		return r;
	endfunction

	// Data length in use: zero acts as one, and it is capped at the largest
	// length whose codeword still fits.
	function automatic int data_len_of(logic [hsec_pkg::CfgW-1:0] raw);
		int m;
		int top;
		m = int'(raw);
		top = 1;
		while (top < 63 && (top + 1) + check_len_of(top + 1) <= MaxCodeBits) begin
			top++;
		end
		if (m < 1) begin
			m = 1;
		end
		if (m > top) begin
			m = top;
		end
		return m;
	endfunction

	// Hamming result for one word at the given register value.
	function automatic result_t hamming_result(logic [hsec_pkg::CfgW-1:0] raw,
			hsec_pkg::op_t op, hsec_pkg::code_t word);
		result_t res;
		int      m;
		int      r;
		int      n;
		int      d;
		logic    par;
		m = data_len_of(raw);
		r = check_len_of(m);
		n = m + r;
		res = '0;
		if (op == hsec_pkg::OP_ENCODE) begin
			// Data bits fill the non-power-of-two positions in rising order.
			d = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (d < m) begin
						res.cw[p-1] = word[d];
					end
					d++;
				end
			end
			// Each check bit makes its group even.
			for (int k = 0; k < r; k++) begin
				par = 1'b0;
				for (int p = 1; p <= n; p++) begin
					if (((p >> k) & 1) != 0 && p != (1 << k)) begin
						par ^= res.cw[p-1];
					end
				end
				res.cw[(1 << k) - 1] = par;
			end
		end else begin
			for (int p = 1; p <= n; p++) begin
				res.cw[p-1] = word[p-1];
			end
			// Group parities form the syndrome.
			for (int k = 0; k < r; k++) begin
				par = 1'b0;
				for (int p = 1; p <= n; p++) begin
					if (((p >> k) & 1) != 0) begin
						par ^= res.cw[p-1];
					end
				end
				res.syn[k] = par;
			end
			if (res.syn != '0 && int'(res.syn) <= n) begin
				res.cw[int'(res.syn) - 1] = ~res.cw[int'(res.syn) - 1];
			end
			res.err = (res.syn != '0);
		end
		return res;
	endfunction

	function automatic hsec_pkg::code_t random_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[hsec_pkg::CodeW-1:0];
	endfunction

	// Offers one word in bursts with random gaps, and records the expected
	// result once the transfer happens.
	task automatic send_word(hsec_pkg::op_t op, hsec_pkg::code_t word, result_t want);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(50, 200);
			end else begin
				burst_left = $urandom_range(1, 12);
			end
		end
		in_valid <= 1'b1;
		in_op <= op;
		in_word <= word;
		do @(posedge clk); while (in_stall);
		awaited_results.push_back(want);
		burst_left--;
	endtask

	// Stops offering words and waits until every result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_data_bits(logic [hsec_pkg::CfgW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output stall pattern: modes of random length with no stall, random
	// stalls, or a periodic pattern of long stalls.
	initial begin
		int mode;
		int span;
		int step;
		out_stall = 1'b0;
		mode = 0;
		span = 0;
		step = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(20, 100);
			end
			span--;
			step++;
			case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					out_stall <= ((step % 12) < 7);
				end
			endcase
		end
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none expected, codeword %h syndrome %0d",
					$time, codeword, syndrome);
				fail_count++;
			end else begin
				got_want = awaited_results.pop_front();
				if (codeword !== got_want.cw) begin
					$display("%0t: codeword mismatch, expected %h, actual %h",
						$time, got_want.cw, codeword);
					fail_count++;
				end
				if (syndrome !== got_want.syn) begin
					$display("%0t: syndrome mismatch, expected %0d, actual %0d",
						$time, got_want.syn, syndrome);
					fail_count++;
				end
				if (error_seen !== got_want.err) begin
					$display("%0t: error_seen mismatch, expected %b, actual %b",
						$time, got_want.err, error_seen);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus.
	initial begin
		int              m;
		int              n;
		int              sel;
		int              flips;
		hsec_pkg::code_t w;
		hsec_pkg::op_t   op;
		result_t         want;
		result_t         enc;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_op = hsec_pkg::OP_ENCODE;
		in_word = '0;
		fail_count = 0;
		burst_left = 0;
		cfg_shadow = hsec_pkg::CfgW'(hsec_pkg::DataBitsReset);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		for (int i = 0; i < DirectedRows; i++) begin
			if (directed_rows[i].wr_cfg) begin
				drain();
				write_data_bits(directed_rows[i].cfg);
			end
			if (directed_rows[i].typed) begin
				want = directed_rows[i].want;
			end else begin
				want = hamming_result(cfg_shadow, directed_rows[i].op,
					directed_rows[i].word);
			end
			send_word(directed_rows[i].op, directed_rows[i].word, want);
		end

		// Random phases, one data length each.
		for (int phase = 0; phase < RandomPhases; phase++) begin
			drain();
			if (phase < 10) begin
				write_data_bits(phase_cfg[phase]);
			end else begin
				write_data_bits(hsec_pkg::CfgW'($urandom_range(0, 63)));
			end
			m = data_len_of(cfg_shadow);
			n = m + check_len_of(m);
			for (int item = 0; item < ItemsPerPhase; item++) begin
				sel = $urandom_range(0, 9);
				if (sel < 3) begin
					// Raw data, sometimes with no bits above the data length.
					op = hsec_pkg::OP_ENCODE;
					w = random_word();
					if ($urandom_range(0, 1) == 0) begin
						w &= (hsec_pkg::code_t'(1) << m) - hsec_pkg::code_t'(1);
					end
				end else if (sel < 8) begin
					// Valid codeword with zero, one or two flipped bits.
					op = hsec_pkg::OP_CHECK;
					enc = hamming_result(cfg_shadow, hsec_pkg::OP_ENCODE, random_word());
					w = enc.cw;
					flips = $urandom_range(0, 9);
					if (flips >= 3) begin
						w[$urandom_range(1, n) - 1] ^= 1'b1;
					end
					if (flips >= 8) begin
						w[$urandom_range(1, n) - 1] ^= 1'b1;
					end
					if ($urandom_range(0, 3) == 0) begin
						w |= random_word() & ~((hsec_pkg::code_t'(1) << n) -
							hsec_pkg::code_t'(1));
					end
				end else begin
					op = hsec_pkg::OP_CHECK;
					w = random_word();
				end
				send_word(op, w, hamming_result(cfg_shadow, op, w));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
